FILE: sv/mlfr_pkg.sv
// Package for the marker/length frame receiver: phase and result codes,
// marker constants and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlfr_pkg;

    localparam int LEN_BITS   = 24;   // payload length width, 8..31
    localparam int MAXLEN_W   = 24;
    localparam int ID_W       = 32;
    localparam int FLD_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 3;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int OUT_DATA_W = BYTE_W + ID_W + MAXLEN_W;

    localparam logic [BYTE_W-1:0]   MARK_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0]   MARK_SUFFIX = 8'hFE;
    localparam logic [1:0]          LAST_FIELD_BYTE = 2'd3;
    localparam logic [MAXLEN_W-1:0] MAX_LEN_RST = '1;

    // register word index in paddr[2]
    localparam logic REG_MAX_LEN = 1'b0;

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'd0,
        PH_ID      = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SUFFIX  = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        K_PAYLOAD    = 3'd0,
        K_GOOD       = 3'd1,
        K_BAD_PREFIX = 3'd2,
        K_BAD_SUFFIX = 3'd3,
        K_BAD_LEN    = 3'd4,
        K_CHAN_ERR   = 3'd5
    } t_out_kind;

endpackage

`default_nettype wire

FILE: sv/marker_length_frame_receiver.sv
// A result word is registered: it appears on the master side in the cycle
// after the input word that yields it is accepted. Throughput: one input word
// per cycle; the output register frees whenever the consumer takes its word,
// so the slave side stalls only while a result is held back by m_axis_tready.
// Reset (synchronous, i_rst_n low): hunting for a prefix, counters and shift
// registers cleared, max_len at all ones, output empty.
// Top level of the frame receiver; uses mlfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module marker_length_frame_receiver (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [mlfr_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                              s_axis_tuser,  // [0] kind
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [mlfr_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [7:0] out_byte,
                                                                  // [39:8] msg_id,
                                                                  // [63:40] msg_len
    output logic [mlfr_pkg::KIND_W-1:0]            m_axis_tuser,  // [2:0] out_kind
    output logic                                   m_axis_tlast,  // last_payload
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mlfr_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [mlfr_pkg::PDATA_W-1:0]      pwdata,
    output logic [mlfr_pkg::PDATA_W-1:0]           prdata,
    output logic                                   pready
);
    import mlfr_pkg::*;

    // parser state
    t_phase                r_phase, n_phase;
    logic [1:0]            r_cnt, n_cnt;
    logic                  r_mis, n_mis;
    logic [FLD_W-1:0]      r_id, n_id;
    logic [FLD_W-1:0]      r_len, n_len;
    logic [LEN_BITS-1:0]   r_rem, n_rem;
    logic [MAXLEN_W-1:0]   r_max_len;

    // output register
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    t_out_kind             r_m_kind;
    logic                  r_m_last;

    // result of the current word
    logic                  res_valid;
    t_out_kind             res_kind;
    logic                  res_last;
    logic [OUT_DATA_W-1:0] res_data;

    logic                  s_acc;
    logic                  full;
    logic [BYTE_W-1:0]     b;
    logic [FLD_W-1:0]      len_next;
    logic                  len_bad;
    logic                  pay_last;

    assign b        = s_axis_tdata;
    assign full     = (r_cnt == LAST_FIELD_BYTE);
    assign len_next = {r_len[FLD_W-BYTE_W-1:0], b};
    assign pay_last = (r_rem <= LEN_BITS'(1));
    // sign bit, bits above LEN_BITS, or over the limit
    assign len_bad  = len_next[FLD_W-1]
                   || (len_next[FLD_W-1:LEN_BITS] != '0)
                   || (len_next > FLD_W'(r_max_len));

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt + 2'd1;
        n_mis   = r_mis;
        n_id    = r_id;
        n_len   = r_len;
        n_rem   = r_rem;
        if (s_axis_tuser) begin
            n_phase = PH_PREFIX;
            n_cnt   = '0;
            n_mis   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    n_cnt = r_cnt;
                    n_rem = r_rem - LEN_BITS'(1);
                    if (pay_last) begin
                        n_rem   = '0;
                        n_phase = PH_SUFFIX;
                        n_cnt   = '0;
                        n_mis   = 1'b0;
                    end
                end
                PH_ID: begin
                    n_id = {r_id[FLD_W-BYTE_W-1:0], b};
                    if (full) begin
                        n_len   = '0;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = len_next;
                    if (full) begin
                        n_mis = 1'b0;
                        if (len_bad) begin
                            n_phase = PH_PREFIX;
                        end else begin
                            n_rem   = len_next[LEN_BITS-1:0];
                            n_phase = (len_next[LEN_BITS-1:0] == '0) ? PH_SUFFIX
                                                                     : PH_PAYLOAD;
                        end
                    end
                end
                PH_SUFFIX: begin
                    n_mis = r_mis || (b != MARK_SUFFIX);
                    if (full) begin
                        n_phase = PH_PREFIX;
                        n_mis   = 1'b0;
                    end
                end
                default: begin   // prefix hunting
                    n_phase = PH_PREFIX;
                    n_mis   = r_mis || (b != MARK_PREFIX);
                    if (full) begin
                        n_mis = 1'b0;
                        if (!(r_mis || (b != MARK_PREFIX))) begin
                            n_id    = '0;
                            n_phase = PH_ID;
                        end
                    end
                end
            endcase
        end
    end

    // result of this word
    always_comb begin
        res_valid = 1'b0;
        res_kind  = K_PAYLOAD;
        res_last  = 1'b0;
        res_data  = '0;
        if (s_axis_tuser) begin
            res_valid = 1'b1;
            res_kind  = K_CHAN_ERR;
        end else begin
            unique case (r_phase)
                PH_PAYLOAD: begin
                    res_valid = 1'b1;
                    res_last  = pay_last;
                    res_data  = OUT_DATA_W'(b);
                end
                PH_ID: begin
                    res_valid = 1'b0;
                end
                PH_LEN: begin
                    res_valid = full && len_bad;
                    res_kind  = K_BAD_LEN;
                end
                PH_SUFFIX: begin
                    res_valid = full;
                    if (r_mis || (b != MARK_SUFFIX)) begin
                        res_kind = K_BAD_SUFFIX;
                    end else begin
                        res_kind = K_GOOD;
                        res_data = {r_len[MAXLEN_W-1:0], r_id, BYTE_W'(0)};
                    end
                end
                default: begin
                    res_valid = full && (r_mis || (b != MARK_PREFIX));
                    res_kind  = K_BAD_PREFIX;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_cnt   <= '0;
            r_mis   <= 1'b0;
            r_id    <= '0;
            r_len   <= '0;
            r_rem   <= '0;
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_mis   <= n_mis;
            r_id    <= n_id;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_acc) begin
            r_m_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && res_valid) begin
            r_m_data <= res_data;
            r_m_kind <= res_kind;
            r_m_last <= res_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tlast  = r_m_last;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_MAX_LEN)) begin
            r_max_len <= pwdata[MAXLEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? PDATA_W'(r_max_len) : '0;

`ifndef SYNTH
    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == K_PAYLOAD))
        else $error("tlast on a non-payload result");

    a_payload_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ((r_rem != '0) && (r_cnt == '0)))
        else $error("payload phase with nothing left to pass");

    a_chan_err_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser)
            |=> (m_axis_tvalid && (m_axis_tuser == K_CHAN_ERR) && (r_phase == PH_PREFIX)))
        else $error("channel error not reported");

    a_good_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != K_PAYLOAD)) |-> (m_axis_tdata[7:0] == '0))
        else $error("byte field set on a status result");
`endif

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for marker_length_frame_receiver: byte-stream stimulus
// with framing faults, a local frame parser as predictor, APB max_len setup.
// Depends on mlfr_pkg and the RTL only.
`timescale 1ns / 1ps

module testbench;
    import mlfr_pkg::*;

    typedef struct packed {
        t_out_kind             kind;
        logic [BYTE_W-1:0]     data;
        logic                  last;
        logic [ID_W-1:0]       id;
        logic [MAXLEN_W-1:0]   len;
    } t_result;

    typedef enum {FLAW_NONE, FLAW_PREFIX, FLAW_SUFFIX, FLAW_CHAN} t_flaw;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // parser state mirrored by the bench
    t_phase                 pr_phase     = PH_PREFIX;
    logic [1:0]             pr_count     = '0;
    logic                   pr_mismatch  = 1'b0;
    logic [FLD_W-1:0]       pr_id        = '0;
    logic [FLD_W-1:0]       pr_len       = '0;
    logic [LEN_BITS-1:0]    pr_remaining = '0;
    logic [MAXLEN_W-1:0]    pr_max_len   = MAX_LEN_RST;

    t_result    expected_q[$];
    t_result    got_result;
    t_result    want_result;
    int         mismatch_count = 0;
    int         words_sent     = 0;
    int         hold_request   = 0;
    bit         src_idle_en    = 1'b0;
    bit         sink_idle_en   = 1'b0;

    marker_length_frame_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] rx_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte, [39:8] msg_id, [63:40] msg_len
        .m_axis_tuser  (m_axis_tuser),   // [2:0] out_kind
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ---------------- frame parser (predictor) ----------------

    task automatic queue_result(input t_out_kind kind, input logic [BYTE_W-1:0] data,
                                input logic last, input logic [ID_W-1:0] id,
                                input logic [MAXLEN_W-1:0] len);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        r.id   = id;
        r.len  = len;
        expected_q.push_back(r);
    endtask

    task automatic restart_hunt();
        pr_phase    = PH_PREFIX;
        pr_count    = '0;
        pr_mismatch = 1'b0;
    endtask

    task automatic parse_word(input logic chan_err, input logic [BYTE_W-1:0] b);
        logic at_fourth;
        logic is_last;
        if (chan_err) begin
            restart_hunt();
            queue_result(K_CHAN_ERR, '0, 1'b0, '0, '0);
            return;
        end
        if (pr_phase == PH_PAYLOAD) begin
            is_last = (pr_remaining <= LEN_BITS'(1));
            queue_result(K_PAYLOAD, b, is_last, '0, '0);
            if (is_last) begin
                pr_remaining = '0;
                pr_phase     = PH_SUFFIX;
                pr_count     = '0;
                pr_mismatch  = 1'b0;
            end else begin
                pr_remaining = pr_remaining - LEN_BITS'(1);
            end
            return;
        end
        at_fourth = (pr_count == LAST_FIELD_BYTE);
        pr_count  = pr_count + 2'd1;
        case (pr_phase)
            PH_PREFIX: begin
                if (b != MARK_PREFIX)
                    pr_mismatch = 1'b1;
                if (at_fourth) begin
                    if (pr_mismatch) begin
                        restart_hunt();
                        queue_result(K_BAD_PREFIX, '0, 1'b0, '0, '0);
                    end else begin
                        pr_id    = '0;
                        pr_phase = PH_ID;
                    end
                end
            end
            PH_ID: begin
                pr_id = {pr_id[FLD_W-BYTE_W-1:0], b};
                if (at_fourth) begin
                    pr_len   = '0;
                    pr_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                pr_len = {pr_len[FLD_W-BYTE_W-1:0], b};
                if (at_fourth) begin
                    // negative, too wide for the counter, or above the limit
                    if (pr_len[FLD_W-1] || pr_len[FLD_W-1:LEN_BITS] != '0 ||
                        pr_len > FLD_W'(pr_max_len)) begin
                        restart_hunt();
                        queue_result(K_BAD_LEN, '0, 1'b0, '0, '0);
                    end else begin
                        pr_remaining = pr_len[LEN_BITS-1:0];
                        pr_count     = '0;
                        pr_mismatch  = 1'b0;
                        pr_phase     = (pr_remaining == '0) ? PH_SUFFIX : PH_PAYLOAD;
                    end
                end
            end
            default: begin
                if (b != MARK_SUFFIX)
                    pr_mismatch = 1'b1;
                if (at_fourth) begin
                    if (pr_mismatch)
                        queue_result(K_BAD_SUFFIX, '0, 1'b0, '0, '0);
                    else
                        queue_result(K_GOOD, '0, 1'b0, pr_id, pr_len[MAXLEN_W-1:0]);
                    restart_hunt();
                end
            end
        endcase
    endtask

    // result check first: a word leaving now belongs to an earlier input word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_result.kind = t_out_kind'(m_axis_tuser);
                got_result.data = m_axis_tdata[7:0];
                got_result.last = m_axis_tlast;
                got_result.id   = m_axis_tdata[39:8];
                got_result.len  = m_axis_tdata[63:40];
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected word kind %0d byte %02h last %0b id %08h len %06h",
                        got_result.kind, got_result.data, got_result.last,
                        got_result.id, got_result.len));
                end else begin
                    want_result = expected_q.pop_front();
                    if (got_result !== want_result)
                        report_mismatch($sformatf(
                            "exp/got kind %0d/%0d byte %02h/%02h last %0b/%0b id %08h/%08h len %06h/%06h",
                            want_result.kind, got_result.kind, want_result.data,
                            got_result.data, want_result.last, got_result.last,
                            want_result.id, got_result.id, want_result.len, got_result.len));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_word(s_axis_tuser, s_axis_tdata);
        end
    end

    // ---------------- receiver side ----------------

    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- sender side ----------------

    task automatic send_word(input logic chan_err, input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= chan_err;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_frame(input logic [ID_W-1:0] id, input logic [FLD_W-1:0] len_word,
                              input int n_payload, input t_flaw flaw);
        logic [BYTE_W-1:0] q[$];
        logic [BYTE_W-1:0] v;
        int cut;
        int k;
        for (k = 0; k < 4; k++) q.push_back(MARK_PREFIX);
        for (k = 3; k >= 0; k--) q.push_back(id[8*k +: 8]);
        for (k = 3; k >= 0; k--) q.push_back(len_word[8*k +: 8]);
        repeat (n_payload) q.push_back(BYTE_W'($urandom));
        for (k = 0; k < 4; k++) q.push_back(MARK_SUFFIX);
        cut = q.size();
        case (flaw)
            FLAW_PREFIX: q[$urandom_range(0, 3)] = BYTE_W'($urandom_range(0, 254));
            FLAW_SUFFIX: begin
                v = BYTE_W'($urandom_range(0, 254));
                if (v == MARK_SUFFIX)
                    v = MARK_PREFIX;
                q[q.size() - 1 - $urandom_range(0, 3)] = v;
            end
            FLAW_CHAN: cut = $urandom_range(0, q.size() - 1);
            default: ;
        endcase
        for (k = 0; k < cut; k++)
            send_word(1'b0, q[k]);
        if (flaw == FLAW_CHAN)
            send_word(1'b1, BYTE_W'($urandom));
    endtask

    // drop valid, let every expected word arrive, then a short settle
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr && addr[2] == REG_MAX_LEN)
            pr_max_len = value[MAXLEN_W-1:0];
        if (!wr && addr[2] == REG_MAX_LEN && prdata !== PDATA_W'(pr_max_len))
            report_mismatch($sformatf("max_len read exp %06h got %08h", pr_max_len, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_max_len(input logic [PDATA_W-1:0] value);
        wait_for_results();
        apb_access(1'b1, {1'b0, 2'b00}, value);
        apb_access(1'b0, {1'b0, 2'b00}, '0);
    endtask

    // ---------------- tests ----------------

    task automatic test_channel_error();
        send_word(1'b1, 8'hA5);               // while hunting
        send_word(1'b0, MARK_PREFIX);
        send_word(1'b0, MARK_PREFIX);
        send_word(1'b1, 8'h00);               // inside a prefix
        send_frame(32'h1234_5678, 32'd3, 3, FLAW_CHAN);
    endtask

    task automatic test_good_frames();
        send_frame(32'hFFFF_FFFF, 32'd0, 0, FLAW_NONE);
        send_frame(32'h0000_0000, 32'd2, 2, FLAW_NONE);
    endtask

    task automatic test_bad_markers();
        send_frame(32'hA5A5_0001, 32'd1, 1, FLAW_PREFIX);
        send_word(1'b1, 8'hFF);
        send_frame(32'hA5A5_0002, 32'd1, 1, FLAW_SUFFIX);
    endtask

    task automatic test_bad_length();
        send_frame(32'hBEEF_0001, 32'h8000_0000, 0, FLAW_NONE);   // negative
        send_frame(32'hBEEF_0002, 32'h0100_0000, 0, FLAW_NONE);   // beyond counter width
    endtask

    task automatic test_max_len();
        set_max_len(32'hFF00_0003);            // upper bits must be dropped
        send_frame($urandom, 32'd3, 3, FLAW_NONE);
        send_frame($urandom, 32'd4, 0, FLAW_NONE);
        wait_for_results();
        apb_access(1'b1, {1'b1, 2'b00}, 32'h0000_0000);   // no register there
        apb_access(1'b0, {1'b0, 2'b00}, '0);
        send_frame($urandom, 32'd3, 3, FLAW_NONE);
        set_max_len(32'h0000_0000);
        send_frame($urandom, 32'd0, 0, FLAW_NONE);
        send_frame($urandom, 32'd1, 0, FLAW_NONE);
        set_max_len(32'h00FF_FFFF);
        // largest length: a few payload words, then the link drops
        send_frame($urandom, 32'h00FF_FFFF, 5, FLAW_NONE);
        send_word(1'b1, 8'h5A);
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        hold_request = 150;
        send_frame($urandom, 32'd40, 40, FLAW_NONE);
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int target;
        int frames;
        int sel;
        int len;
        logic [FLD_W-1:0] len_word;
        target = words_sent + 470;
        frames = 0;
        while (words_sent < target) begin
            if (frames % 8 == 0) begin
                case ($urandom_range(0, 4))
                    0: set_max_len({8'($urandom), 24'hFF_FFFF});
                    1: set_max_len({8'($urandom), 24'h00_0000});
                    2, 3: set_max_len({8'($urandom), 24'($urandom_range(0, 40))});
                    default: set_max_len($urandom);
                endcase
            end
            frames++;
            if (target - words_sent < 150) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else if (frames % 4 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (len > int'(pr_max_len))
                len = int'(pr_max_len);
            sel = $urandom_range(0, 99);
            if (sel < 72) begin
                send_frame($urandom, len, len, FLAW_NONE);
            end else if (sel < 90) begin
                send_frame($urandom, len, len,
                           sel < 78 ? FLAW_PREFIX : (sel < 84 ? FLAW_SUFFIX : FLAW_CHAN));
            end else if (sel < 95) begin
                case ($urandom_range(0, 2))
                    0: len_word = {1'b1, 31'($urandom)};
                    1: len_word = {1'b0, 7'($urandom_range(1, 127)), 24'($urandom)};
                    default: len_word = (pr_max_len == 24'hFF_FFFF) ? 32'h8000_0000 :
                                        FLD_W'(pr_max_len) + 1 + $urandom_range(0, 5);
                endcase
                send_frame($urandom, len_word, 0, FLAW_NONE);
            end else begin
                repeat ($urandom_range(1, 7))
                    send_word($urandom_range(0, 7) == 0, BYTE_W'($urandom));
            end
            // resync byte alignment after most faults
            if (sel >= 72 && $urandom_range(0, 4) != 0)
                send_word(1'b1, BYTE_W'($urandom));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        apb_access(1'b0, {1'b0, 2'b00}, '0);   // reset value
        test_channel_error();
        test_good_frames();
        test_bad_markers();
        test_bad_length();
        test_max_len();
        test_output_backpressure();
        test_random_frames();

        wait_for_results();
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
